### rtl/core/jdc_pkg.sv
// Shared types, constants and lookup functions of the Julian day to calendar date converter.
`timescale 1ns / 1ps
package jdc_pkg;

  localparam int unsigned JD_W    = 24;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned B_W     = 24;
  localparam int unsigned C_W     = 15;
  localparam int unsigned T_W     = 10;
  localparam int unsigned E_W     = 5;

  localparam logic [JD_W-1:0] JD_MIN       = 24'd4749;
  localparam logic [JD_W-1:0] JD_MAX       = 24'd10852487;
  localparam logic [JD_W-1:0] JD_GREGORIAN = 24'd2299161;

  // 4 * 1867216 + 1, subtracted from 4 * jd before the century division
  localparam logic [25:0] GREG_BIAS  = 26'd7468865;
  localparam logic [24:0] B_OFFSET   = 25'd1524;
  localparam logic [30:0] C_OFFSET   = 31'd12210;
  localparam logic [15:0] YEAR_BIAS  = 16'd4715;

  // Exact floor division by constants: multiply by ceil(2^s / d), s = k + ceil(log2 d)
  localparam int unsigned DIV1_SHIFT = 44;
  localparam int unsigned DIV1_MUL_W = 27;
  localparam logic [DIV1_MUL_W-1:0] DIV1_MUL =
    DIV1_MUL_W'(((64'd1 << DIV1_SHIFT) + 64'd146096) / 64'd146097);

  localparam int unsigned DIV2_SHIFT = 47;
  localparam int unsigned DIV2_MUL_W = 32;
  localparam logic [DIV2_MUL_W-1:0] DIV2_MUL =
    DIV2_MUL_W'(((64'd1 << DIV2_SHIFT) + 64'd36524) / 64'd36525);

  localparam int unsigned DIV3_SHIFT = 43;
  localparam int unsigned DIV3_MUL_W = 25;
  localparam logic [DIV3_MUL_W-1:0] DIV3_MUL =
    DIV3_MUL_W'(((64'd1 << DIV3_SHIFT) + 64'd306000) / 64'd306001);

  typedef struct packed {
    logic           in_range;
    logic [B_W-1:0] b;
  } jdc_b_t;

  typedef struct packed {
    logic           in_range;
    logic [C_W-1:0] c;
    logic [T_W-1:0] t;
  } jdc_ct_t;

  // floor(30.6001 * e)
  function automatic logic [8:0] jdc_month_start(input logic [E_W-1:0] e);
    logic [8:0] v;
    unique case (e)
      5'd1:    v = 9'd30;
      5'd2:    v = 9'd61;
      5'd3:    v = 9'd91;
      5'd4:    v = 9'd122;
      5'd5:    v = 9'd153;
      5'd6:    v = 9'd183;
      5'd7:    v = 9'd214;
      5'd8:    v = 9'd244;
      5'd9:    v = 9'd275;
      5'd10:   v = 9'd306;
      5'd11:   v = 9'd336;
      5'd12:   v = 9'd367;
      5'd13:   v = 9'd397;
      5'd14:   v = 9'd428;
      5'd15:   v = 9'd459;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/julian_day_to_calendar_date.sv
// Top level of the Julian day number to calendar date converter.
// Converts a whole Julian day number into day, month and year (Julian calendar before day
// 2299161, Gregorian from it on, negative years BC, no year zero). Numbers outside
// 4749..10852487 return out_valid_res low with zero day, month and year. A request is taken
// every cycle unless a stall has filled the pipeline; each passes six register stages. The
// three constant divisions are done as multiplications by exact reciprocals, each with a
// register behind it, and these set the stage split. Stalls hold every stage in place and
// gaps between requests are closed up.
`timescale 1ns / 1ps
module julian_day_to_calendar_date
  import jdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [JD_W-1:0]          in_julian_day,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DAY_W-1:0]         out_day_of_month,
  output logic [MONTH_W-1:0]       out_month_number,
  output logic signed [YEAR_W-1:0] out_year_number,
  output logic                     out_valid_res
);

  logic    b_valid, b_ready;
  jdc_b_t  b_data;
  logic    ct_valid, ct_ready;
  jdc_ct_t ct_data;

  jdc_gregorian u_greg (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_julian_day (in_julian_day),
    .out_valid     (b_valid),
    .out_ready     (b_ready),
    .out_data      (b_data)
  );

  jdc_year u_year (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_data   (b_data),
    .out_valid (ct_valid),
    .out_ready (ct_ready),
    .out_data  (ct_data)
  );

  jdc_month_day u_md (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (ct_valid),
    .in_ready         (ct_ready),
    .in_data          (ct_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_day_of_month (out_day_of_month),
    .out_month_number (out_month_number),
    .out_year_number  (out_year_number),
    .out_valid_res    (out_valid_res)
  );

endmodule

### rtl/core/jdc_gregorian.sv
// Range check, Gregorian century correction and shifted day count b (two stages).
`timescale 1ns / 1ps
module jdc_gregorian
  import jdc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [JD_W-1:0] in_julian_day,
  output logic            out_valid,
  input  logic            out_ready,
  output jdc_b_t          out_data
);

  localparam int unsigned P1_W = 26 + DIV1_MUL_W;

  logic            v1_r, v2_r;
  logic            rdy1, rdy2;
  logic [JD_W-1:0] jd1_r;
  logic            greg1_r, rng1_r, greg1_nxt, rng1_nxt;
  logic [P1_W-1:0] p1_r, p1_nxt;
  logic [25:0]     n1;
  logic [8:0]      alpha;
  logic [24:0]     a_sum;
  jdc_b_t          s2_r, s2_nxt;

  assign rdy2     = ~v2_r | out_ready;
  assign rdy1     = ~v1_r | rdy2;
  assign in_ready = rdy1;

  always_comb begin
    n1        = {in_julian_day, 2'b00} - GREG_BIAS;
    p1_nxt    = P1_W'(n1) * P1_W'(DIV1_MUL);
    greg1_nxt = in_julian_day >= JD_GREGORIAN;
    rng1_nxt  = (in_julian_day >= JD_MIN) && (in_julian_day <= JD_MAX);
  end

  always_comb begin
    alpha           = p1_r[DIV1_SHIFT+8:DIV1_SHIFT];
    a_sum           = 25'(jd1_r) + 25'd1 + 25'(alpha) - 25'(alpha[8:2]);
    s2_nxt.in_range = rng1_r;
    s2_nxt.b        = greg1_r ? B_W'(a_sum + B_OFFSET) : B_W'(25'(jd1_r) + B_OFFSET);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      jd1_r   <= in_julian_day;
      greg1_r <= greg1_nxt;
      rng1_r  <= rng1_nxt;
      p1_r    <= p1_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = s2_r;

endmodule

### rtl/core/jdc_year.sv
// Year count c and day offset within the year t from b (two stages).
`timescale 1ns / 1ps
module jdc_year
  import jdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  jdc_b_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output jdc_ct_t out_data
);

  localparam int unsigned P2_W = 31 + DIV2_MUL_W;

  logic            v3_r, v4_r;
  logic            rdy3, rdy4;
  jdc_b_t          s3_r;
  logic [P2_W-1:0] p2_r, p2_nxt;
  logic [30:0]     n2;
  logic [C_W-1:0]  c;
  logic [B_W-1:0]  d;
  jdc_ct_t         s4_r, s4_nxt;

  assign rdy4     = ~v4_r | out_ready;
  assign rdy3     = ~v3_r | rdy4;
  assign in_ready = rdy3;

  always_comb begin
    n2     = 31'(in_data.b) * 31'd100 - C_OFFSET;
    p2_nxt = P2_W'(n2) * P2_W'(DIV2_MUL);
  end

  always_comb begin
    c               = p2_r[DIV2_SHIFT+C_W-1:DIV2_SHIFT];
    d               = B_W'(c) * B_W'(365) + B_W'(c[C_W-1:2]);
    s4_nxt.in_range = s3_r.in_range;
    s4_nxt.c        = c;
    s4_nxt.t        = T_W'(s3_r.b - d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= in_valid;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      s3_r <= in_data;
      p2_r <= p2_nxt;
    end
    if (rdy4 && v3_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = s4_r;

endmodule

### rtl/core/jdc_month_day.sv
// Month index, day of month and final year with output register (two stages).
`timescale 1ns / 1ps
module jdc_month_day
  import jdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  jdc_ct_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DAY_W-1:0]         out_day_of_month,
  output logic [MONTH_W-1:0]       out_month_number,
  output logic signed [YEAR_W-1:0] out_year_number,
  output logic                     out_valid_res
);

  localparam int unsigned P3_W = 24 + DIV3_MUL_W;

  logic                     v5_r, v6_r;
  logic                     rdy5, rdy6;
  jdc_ct_t                  s5_r;
  logic [P3_W-1:0]          p3_r, p3_nxt;
  logic [23:0]              n3;
  logic [E_W-1:0]           e;
  logic [MONTH_W-1:0]       m0, month;
  logic signed [YEAR_W-1:0] yr0, yr1, yr;
  logic [DAY_W-1:0]         day_r, day_nxt;
  logic [MONTH_W-1:0]       month_r, month_nxt;
  logic signed [YEAR_W-1:0] year_r, year_nxt;
  logic                     res_r;

  assign rdy6     = ~v6_r | out_ready;
  assign rdy5     = ~v5_r | rdy6;
  assign in_ready = rdy5;

  always_comb begin
    n3     = 24'(in_data.t) * 24'd10000;
    p3_nxt = P3_W'(n3) * P3_W'(DIV3_MUL);
  end

  always_comb begin
    e     = p3_r[DIV3_SHIFT+E_W-1:DIV3_SHIFT];
    m0    = MONTH_W'(e - 5'd1);
    month = (m0 > 4'd12) ? m0 - 4'd12 : m0;
    yr0   = $signed(YEAR_W'(s5_r.c) - YEAR_BIAS);
    yr1   = (month > 4'd2) ? yr0 - 16'sd1 : yr0;
    yr    = (yr1 <= 16'sd0) ? yr1 - 16'sd1 : yr1;
    if (s5_r.in_range) begin
      day_nxt   = DAY_W'(s5_r.t - T_W'(jdc_month_start(e)));
      month_nxt = month;
      year_nxt  = yr;
    end else begin
      day_nxt   = '0;
      month_nxt = '0;
      year_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy5) v5_r <= in_valid;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && in_valid) begin
      s5_r <= in_data;
      p3_r <= p3_nxt;
    end
    if (rdy6 && v5_r) begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      res_r   <= s5_r.in_range;
    end
  end

  assign out_valid        = v6_r;
  assign out_day_of_month = day_r;
  assign out_month_number = month_r;
  assign out_year_number  = year_r;
  assign out_valid_res    = res_r;

endmodule

### rtl/core/jdc_checker.sv
// Port-level checks on the Julian day to calendar date converter and their binding.
`timescale 1ns / 1ps
module jdc_checker
  import jdc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [JD_W-1:0]          in_julian_day,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [DAY_W-1:0]         out_day_of_month,
  input logic [MONTH_W-1:0]       out_month_number,
  input logic signed [YEAR_W-1:0] out_year_number,
  input logic                     out_valid_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_day_of_month) &&
      $stable(out_month_number) && $stable(out_year_number) && $stable(out_valid_res))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |->
      out_day_of_month == '0 && out_month_number == '0 && out_year_number == '0)
    else $error("out of range request gave a non-zero date");

  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |->
      out_day_of_month >= 5'd1 && out_month_number >= 4'd1 && out_month_number <= 4'd12 &&
      out_year_number != 16'sd0)
    else $error("in range request gave an impossible date");

endmodule

bind julian_day_to_calendar_date jdc_checker u_jdc_checker (.*);
